// File: hw/rtl/lrce_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the lidar range cluster extractor.
// No dependencies; every other file of the block imports this package.
package lrce_pkg;

	localparam int LRCE_NUM_BEAMS    = 512;
	localparam int LRCE_CORDIC_STEPS = 16;

	localparam int RANGE_W  = 16;
	localparam int XY_W     = 17;
	localparam int BEAM_OUT_W = 9;
	localparam int COUNT_W  = 7;
	localparam int START_W  = 23;
	localparam int STEP_W   = 17;
	localparam int ANGLE_W  = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 72;

	localparam int TWO_PI_URAD  = 6283185;
	localparam int PI_URAD      = 3141593;
	localparam int HALF_PI_URAD = 1570796;
	localparam longint GAIN_Q30 = 652032874;
	localparam int GAIN_W       = 30;

	localparam logic [15:0] RST_MIN_RANGE  = 16'd50;
	localparam logic [15:0] RST_NEAR_LIMIT = 16'd1000;
	localparam logic signed [22:0] RST_ANGLE_START = -23'sd1570000;
	localparam logic [16:0] RST_ANGLE_STEP = 17'd10000;
	localparam logic [6:0]  RST_MAX_OBST   = 7'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_RANGE   = 3'd0,
		REG_NEAR_LIMIT  = 3'd1,
		REG_ANGLE_START = 3'd2,
		REG_ANGLE_STEP  = 3'd3,
		REG_MAX_OBST    = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_CORDIC,
		ST_OBS,
		ST_SUM
	} ctrl_st_t;

	typedef enum logic [2:0] {
		AS_IDLE,
		AS_SUM,
		AS_WRAP,
		AS_RED,
		AS_FOLD1,
		AS_FOLD2
	} ang_st_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ITER,
		CS_ROUND
	} cor_st_t;

	typedef struct packed {
		logic                      done;
		logic                      neg;
		logic signed [ANGLE_W-1:0] angle;
	} ang_res_t;

	typedef struct packed {
		logic                   done;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
	} cor_res_t;

	function automatic logic [19:0] atan_urad(input logic [4:0] idx);
		logic [19:0] v;
		case (idx)
			5'd0:    v = 20'd785398;
			5'd1:    v = 20'd463648;
			5'd2:    v = 20'd244979;
			5'd3:    v = 20'd124355;
			5'd4:    v = 20'd62419;
			5'd5:    v = 20'd31240;
			5'd6:    v = 20'd15624;
			5'd7:    v = 20'd7812;
			5'd8:    v = 20'd3906;
			5'd9:    v = 20'd1953;
			5'd10:   v = 20'd977;
			5'd11:   v = 20'd488;
			5'd12:   v = 20'd244;
			5'd13:   v = 20'd122;
			5'd14:   v = 20'd61;
			5'd15:   v = 20'd31;
			5'd16:   v = 20'd15;
			5'd17:   v = 20'd8;
			5'd18:   v = 20'd4;
			5'd19:   v = 20'd2;
			5'd20:   v = 20'd1;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/lidar_range_cluster_extractor_core.sv
// Top level: configuration registers, cluster tracking, sequencer and output register.
// Depends on lrce_pkg, lrce_angle and lrce_cordic.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------------
//  s_axis   | in        | tdata range_mm; tlast end_of_scan
//  m_axis   | out       | tdata x, y, start_beam, nearest range, count; tlast summary
//  cfg      | in        | write enable, register index, write data
//
// A beam that closes no cluster leaves the sequencer in its idle state. A beam that closes
// a cluster under the obstacle limit passes through the angle unit (K + 1 reduction steps,
// K = 2 or more, set by NUM_BEAMS) and then the CORDIC unit before its result is loaded. An
// end-of-scan beam also loads the summary result. Reset clears all cluster state and loads
// the register defaults. A stalled output holds the sequencer before the next request is taken.
module lidar_range_cluster_extractor_core import lrce_pkg::*; #(
	parameter int NUM_BEAMS    = LRCE_NUM_BEAMS,
	parameter int CORDIC_STEPS = LRCE_CORDIC_STEPS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] range_mm
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // [16:0] obstacle_x_mm, [33:17] obstacle_y_mm,
	                                         // [42:34] start_beam, [58:43] nearest_range_mm,
	                                         // [65:59] obstacle_count, [71:66] zero
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BW = $clog2(NUM_BEAMS);

	logic [15:0]              min_q, near_lim_q;
	logic signed [START_W-1:0] ang_start_q;
	logic [STEP_W-1:0]        ang_step_q;
	logic [COUNT_W-1:0]       max_obst_q;

	logic                     open_q;
	logic [RANGE_W-1:0]       nearest_q;
	logic [BW-1:0]            first_q, beam_q;
	logic [COUNT_W-1:0]       count_q;

	logic [BW-1:0]            job_beam_q;
	logic [RANGE_W-1:0]       job_range_q;
	logic [COUNT_W-1:0]       job_count_q, sum_count_q;
	logic                     job_last_q;

	ctrl_st_t                 state_q, state_d;
	logic                     acc, near, emit, ang_start, cor_start, out_free, load_obs, load_sum;
	logic [RANGE_W-1:0]       rng;
	logic [COUNT_W-1:0]       count_inc;
	ang_res_t                 ang_res;
	cor_res_t                 cor_res;

	logic                     m_tvalid_q, m_tlast_q;
	logic [M_DATA_W-1:0]      m_tdata_q;

	assign rng       = s_tdata[RANGE_W-1:0];
	assign acc       = s_tvalid && s_tready;
	assign near      = (rng > min_q) && (rng < near_lim_q);
	assign emit      = !near && open_q && (count_q < max_obst_q);
	assign count_inc = count_q + 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= RST_MIN_RANGE;
			near_lim_q  <= RST_NEAR_LIMIT;
			ang_start_q <= RST_ANGLE_START;
			ang_step_q  <= RST_ANGLE_STEP;
			max_obst_q  <= RST_MAX_OBST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_MIN_RANGE:   min_q       <= cfg_data[15:0];
				REG_NEAR_LIMIT:  near_lim_q  <= cfg_data[15:0];
				REG_ANGLE_START: ang_start_q <= signed'(cfg_data[START_W-1:0]);
				REG_ANGLE_STEP:  ang_step_q  <= cfg_data[STEP_W-1:0];
				REG_MAX_OBST:    max_obst_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			nearest_q <= '0;
			first_q   <= '0;
			beam_q    <= '0;
			count_q   <= '0;
		end else if (acc) begin
			if (s_tlast) begin
				open_q    <= 1'b0;
				nearest_q <= '0;
				first_q   <= '0;
				beam_q    <= '0;
				count_q   <= '0;
			end else begin
				if (near) begin
					if (!open_q) begin
						open_q    <= 1'b1;
						nearest_q <= rng;
						first_q   <= beam_q;
					end else if (rng < nearest_q) begin
						nearest_q <= rng;
					end
				end else if (open_q) begin
					open_q <= 1'b0;
					if (emit) count_q <= count_inc;
				end
				if (beam_q != BW'(NUM_BEAMS - 1)) beam_q <= beam_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			job_beam_q  <= first_q;
			job_range_q <= nearest_q;
			job_count_q <= count_inc;
			job_last_q  <= s_tlast;
			sum_count_q <= emit ? count_inc : count_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ang_start = 1'b0;
		cor_start = 1'b0;
		load_obs  = 1'b0;
		load_sum  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (acc) begin
					if (emit) begin
						ang_start = 1'b1;
						state_d   = ST_ANGLE;
					end else if (s_tlast) begin
						state_d = ST_SUM;
					end
				end
			end
			ST_ANGLE: begin
				if (ang_res.done) begin
					cor_start = 1'b1;
					state_d   = ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				if (cor_res.done) state_d = ST_OBS;
			end
			ST_OBS: begin
				if (out_free) begin
					load_obs = 1'b1;
					state_d  = job_last_q ? ST_SUM : ST_IDLE;
				end
			end
			ST_SUM: begin
				if (out_free) begin
					load_sum = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	lrce_angle #(
		.NUM_BEAMS(NUM_BEAMS)
	) u_angle (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (ang_start),
		.beam       (first_q),
		.angle_start(ang_start_q),
		.angle_step (ang_step_q),
		.res        (ang_res)
	);

	lrce_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.range_mm(job_range_q),
		.angle   (ang_res.angle),
		.neg     (ang_res.neg),
		.res     (cor_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                  m_tvalid_q <= 1'b0;
		else if (load_obs || load_sum) m_tvalid_q <= 1'b1;
		else if (m_tready)            m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_obs) begin
			m_tdata_q <= {6'd0, job_count_q, job_range_q, BEAM_OUT_W'(job_beam_q),
				cor_res.y, cor_res.x};
			m_tlast_q <= 1'b0;
		end else if (load_sum) begin
			m_tdata_q <= {6'd0, sum_count_q, 59'd0};
			m_tlast_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cor_res.done |-> state_q == ST_CORDIC)
		else $error("cordic result outside its wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		ang_res.done |-> state_q == ST_ANGLE)
		else $error("angle result outside its wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !emit && !s_tlast) |=> s_tready)
		else $error("plain beam request stalled the sequencer");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tdata[58:0] == 59'd0)
		else $error("summary result carries obstacle data");

	assert property (@(posedge clk) disable iff (!arst_n)
		beam_q <= BW'(NUM_BEAMS - 1))
		else $error("beam position past the last beam");

endmodule

// File: hw/rtl/lrce_angle.sv
// Beam angle unit: multiply beam by step, then wrap and fold the angle with one shared adder.
// Depends on lrce_pkg.
module lrce_angle import lrce_pkg::*; #(
	parameter int NUM_BEAMS = LRCE_NUM_BEAMS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [$clog2(NUM_BEAMS)-1:0]     beam,
	input  logic signed [START_W-1:0]        angle_start,
	input  logic [STEP_W-1:0]                angle_step,
	output ang_res_t                         res
);

	localparam int BW = $clog2(NUM_BEAMS);
	localparam int PW = BW + STEP_W;
	localparam int AW = (PW > 23) ? PW : 23;
	localparam int VW = AW + 3;
	localparam int K  = AW - 21;
	localparam int CW = $clog2(K + 1);
	localparam logic signed [VW-1:0] TWO_PI_V  = VW'(TWO_PI_URAD);
	localparam logic signed [VW-1:0] PI_V      = VW'(PI_URAD);
	localparam logic signed [VW-1:0] HALF_PI_V = VW'(HALF_PI_URAD);
	localparam logic signed [VW-1:0] RED_TOP   = TWO_PI_V <<< K;

	ang_st_t state_q, state_d;
	logic [PW-1:0]          prod_q;
	logic signed [VW-1:0]   v_q, v_d;
	logic signed [VW-1:0]   sub_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q, neg_d;
	logic                   done_q, done_d;
	logic signed [VW-1:0]   op_a, op_b, alu;
	logic                   op_sub;

	assign alu = op_sub ? (op_a - op_b) : (op_a + op_b);

	always_comb begin
		state_d = state_q;
		v_d     = v_q;
		neg_d   = neg_q;
		done_d  = 1'b0;
		op_a    = v_q;
		op_b    = TWO_PI_V;
		op_sub  = 1'b0;
		unique case (state_q)
			AS_IDLE: begin
				if (start) state_d = AS_SUM;
			end
			AS_SUM: begin
				op_a    = VW'(angle_start);
				op_b    = signed'({{(VW-PW){1'b0}}, prod_q});
				v_d     = alu;
				state_d = AS_WRAP;
			end
			AS_WRAP: begin
				if (v_q < 0) v_d = alu;
				state_d = AS_RED;
			end
			AS_RED: begin
				op_b   = sub_q;
				op_sub = 1'b1;
				if (v_q >= sub_q) v_d = alu;
				if (cnt_q == CW'(K)) state_d = AS_FOLD1;
			end
			AS_FOLD1: begin
				op_sub = 1'b1;
				if (v_q >= PI_V) v_d = alu;
				state_d = AS_FOLD2;
			end
			AS_FOLD2: begin
				op_b  = PI_V;
				neg_d = 1'b0;
				if (v_q > HALF_PI_V) begin
					op_sub = 1'b1;
					v_d    = alu;
					neg_d  = 1'b1;
				end else if (v_q < -HALF_PI_V) begin
					v_d   = alu;
					neg_d = 1'b1;
				end
				done_d  = 1'b1;
				state_d = AS_IDLE;
			end
			default: state_d = AS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		v_q   <= v_d;
		neg_q <= neg_d;
		if (state_q == AS_IDLE && start)
			prod_q <= {{STEP_W{1'b0}}, beam} * {{BW{1'b0}}, angle_step};
		if (state_q == AS_WRAP) begin
			sub_q <= RED_TOP;
			cnt_q <= '0;
		end else if (state_q == AS_RED) begin
			sub_q <= sub_q >>> 1;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign res.done  = done_q;
	assign res.neg   = neg_q;
	assign res.angle = ANGLE_W'(v_q);

endmodule

// File: hw/rtl/lrce_cordic.sv
// Iterative CORDIC rotator: one shift-add stage reused for every step, then round and saturate.
// Depends on lrce_pkg.
module lrce_cordic import lrce_pkg::*; #(
	parameter int CORDIC_STEPS = LRCE_CORDIC_STEPS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [RANGE_W-1:0]         range_mm,
	input  logic signed [ANGLE_W-1:0]  angle,
	input  logic                       neg,
	output cor_res_t                   res
);

	localparam int XW = 35;
	localparam int ZW = 23;
	localparam int IW = $clog2(CORDIC_STEPS);
	localparam int PW = RANGE_W + GAIN_W;
	localparam int RW = XW + 1;
	localparam logic [GAIN_W-1:0] GAIN = GAIN_W'(GAIN_Q30);
	localparam logic signed [RW-1:0] HALF_LSB = RW'(32768);
	localparam logic signed [RW-17:0] SAT_HI = (RW-16)'(65535);

	cor_st_t state_q, state_d;
	logic signed [XW-1:0] x_q, y_q, dx, dy;
	logic signed [ZW-1:0] z_q, at;
	logic [IW-1:0]        i_q;
	logic                 neg_q;
	logic [PW-1:0]        gain_prod;
	logic signed [RW-1:0] rx, ry;
	logic signed [RW-17:0] sx, sy;
	logic signed [XY_W-1:0] ox_q, oy_q;
	logic                 done_q;

	function automatic logic signed [XY_W-1:0] sat17(input logic signed [RW-17:0] v);
		logic signed [XY_W-1:0] r;
		if (v > SAT_HI)       r = XY_W'(65535);
		else if (v < -SAT_HI) r = -XY_W'(65535);
		else                  r = XY_W'(v);
		return r;
	endfunction

	assign gain_prod = {{GAIN_W{1'b0}}, range_mm} * {{RANGE_W{1'b0}}, GAIN};
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = signed'({{(ZW-20){1'b0}}, atan_urad(5'(i_q))});
	assign rx = neg_q ? (HALF_LSB - RW'(x_q)) : (RW'(x_q) + HALF_LSB);
	assign ry = neg_q ? (HALF_LSB - RW'(y_q)) : (RW'(y_q) + HALF_LSB);
	assign sx = (RW-16)'(rx >>> 16);
	assign sy = (RW-16)'(ry >>> 16);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE:  if (start) state_d = CS_ITER;
			CS_ITER:  if (i_q == IW'(CORDIC_STEPS - 1)) state_d = CS_ROUND;
			CS_ROUND: state_d = CS_IDLE;
			default:  state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == CS_ROUND);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			CS_IDLE: begin
				if (start) begin
					x_q   <= signed'({{(XW-32){1'b0}}, gain_prod[PW-1:14]});
					y_q   <= '0;
					z_q   <= ZW'(angle);
					neg_q <= neg;
					i_q   <= '0;
				end
			end
			CS_ITER: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				i_q <= i_q + 1'b1;
			end
			CS_ROUND: begin
				ox_q <= sat17(sx);
				oy_q <= sat17(sy);
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.x    = ox_q;
	assign res.y    = oy_q;

endmodule

// File: test/tb.sv
// Self-checking testbench for lidar_range_cluster_extractor_core: drives beams and register
// writes, predicts obstacles and scan summaries in-bench, compares every result field.
// Depends on lrce_pkg and the core RTL only.
module tb;
	import lrce_pkg::*;

	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int SETTLE_CYCLES = 80;
	localparam int CORDIC_ITERS = (LRCE_CORDIC_STEPS > 24) ? 24 : LRCE_CORDIC_STEPS;
	localparam longint FULL_TURN = 6283185;
	localparam longint HALF_TURN = 3141593;
	localparam longint QUARTER_TURN = 1570796;
	localparam longint CORDIC_GAIN_Q30 = 652032874;
	localparam longint XY_LIMIT = 65535;
	localparam int REG_SPARE_FIRST = 5;

	typedef struct {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic [BEAM_OUT_W-1:0]  beam;
		logic [RANGE_W-1:0]     nearest;
		logic                   summary;
		logic [COUNT_W-1:0]     count;
	} report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;   // [15:0] range_mm
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;   // [16:0] x, [33:17] y, [42:34] start_beam,
	                                  // [58:43] nearest_range_mm, [65:59] obstacle_count
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;

	longint atan_lut [0:23] = '{785398, 463648, 244979, 124355, 62419, 31240, 15624, 7812,
		3906, 1953, 977, 488, 244, 122, 61, 31, 15, 8, 4, 2, 1, 0, 0, 0};

	logic [RANGE_W-1:0]       cfg_min = RST_MIN_RANGE;
	logic [RANGE_W-1:0]       cfg_near = RST_NEAR_LIMIT;
	logic signed [START_W-1:0] cfg_start = RST_ANGLE_START;
	logic [STEP_W-1:0]        cfg_step = RST_ANGLE_STEP;
	logic [COUNT_W-1:0]       cfg_max = RST_MAX_OBST;

	logic                  trk_open = 1'b0;
	logic [RANGE_W-1:0]    trk_nearest = '0;
	logic [BEAM_OUT_W-1:0] trk_first = '0;
	logic [BEAM_OUT_W-1:0] trk_beam = '0;
	logic [COUNT_W-1:0]    trk_count = '0;

	report_t pending_reports [$];

	int     mismatches = 0;
	int     beams_sent = 0;
	int     obstacles_seen = 0;
	int     summaries_seen = 0;
	longint cycles = 0;
	bit     src_jitter = 1'b1;
	bit     sink_jitter = 1'b1;

	lidar_range_cluster_extractor_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 80)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic signed [XY_W-1:0] round_to_mm(input longint q16);
		longint v;
		v = (q16 + 32768) >>> 16;
		if (v > XY_LIMIT)
			v = XY_LIMIT;
		if (v < -XY_LIMIT)
			v = -XY_LIMIT;
		return v[XY_W-1:0];
	endfunction

	function automatic void obstacle_position(input logic [RANGE_W-1:0] rng,
		input logic [BEAM_OUT_W-1:0] beam, output logic signed [XY_W-1:0] xo,
		output logic signed [XY_W-1:0] yo);
		longint ang;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		bit     flip;
		ang = longint'(cfg_start) + longint'(beam) * longint'(cfg_step);
		z = ang % FULL_TURN;
		if (z < 0)
			z += FULL_TURN;
		if (z >= HALF_TURN)
			z -= FULL_TURN;
		flip = 1'b0;
		if (z > QUARTER_TURN) begin
			z -= HALF_TURN;
			flip = 1'b1;
		end else if (z < -QUARTER_TURN) begin
			z += HALF_TURN;
			flip = 1'b1;
		end
		x = (longint'(rng) * CORDIC_GAIN_Q30) >>> 14;
		y = 0;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_lut[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_lut[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		xo = round_to_mm(x);
		yo = round_to_mm(y);
	endfunction

	task automatic track_beam(input logic [RANGE_W-1:0] rng, input logic eos);
		report_t rep;
		logic    is_near;
		is_near = (rng > cfg_min) && (rng < cfg_near);
		if (is_near) begin
			if (!trk_open) begin
				trk_open = 1'b1;
				trk_nearest = rng;
				trk_first = trk_beam;
			end else if (rng < trk_nearest) begin
				trk_nearest = rng;
			end
		end else if (trk_open) begin
			if (trk_count < cfg_max) begin
				trk_count++;
				obstacle_position(trk_nearest, trk_first, rep.x, rep.y);
				rep.beam = trk_first;
				rep.nearest = trk_nearest;
				rep.summary = 1'b0;
				rep.count = trk_count;
				pending_reports.push_back(rep);
			end
			trk_open = 1'b0;
		end
		if (trk_beam < LRCE_NUM_BEAMS - 1)
			trk_beam++;
		if (eos) begin
			rep.x = '0;
			rep.y = '0;
			rep.beam = '0;
			rep.nearest = '0;
			rep.summary = 1'b1;
			rep.count = trk_count;
			pending_reports.push_back(rep);
			trk_open = 1'b0;
			trk_nearest = '0;
			trk_first = '0;
			trk_beam = '0;
			trk_count = '0;
		end
	endtask

	task automatic send_beam(input logic [RANGE_W-1:0] rng, input logic eos);
		int gap;
		gap = (src_jitter && $urandom_range(99, 0) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= rng;
		s_tlast <= eos;
		do @(posedge clk); while (!s_tready);
		track_beam(rng, eos);
		beams_sent++;
	endtask

	// hold off requests until every predicted result has drained
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value;
		case (addr)
			REG_MIN_RANGE:   cfg_min = value[RANGE_W-1:0];
			REG_NEAR_LIMIT:  cfg_near = value[RANGE_W-1:0];
			REG_ANGLE_START: cfg_start = value[START_W-1:0];
			REG_ANGLE_STEP:  cfg_step = value[STEP_W-1:0];
			REG_MAX_OBST:    cfg_max = value[COUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] min_mm, input logic [CFG_DATA_W-1:0] near_mm,
		input logic [CFG_DATA_W-1:0] start_urad, input logic [CFG_DATA_W-1:0] step_urad,
		input logic [CFG_DATA_W-1:0] max_obst);
		write_reg(REG_MIN_RANGE, min_mm);
		write_reg(REG_NEAR_LIMIT, near_mm);
		write_reg(REG_ANGLE_START, start_urad);
		write_reg(REG_ANGLE_STEP, step_urad);
		write_reg(REG_MAX_OBST, max_obst);
	endtask

	function automatic logic [RANGE_W-1:0] near_value();
		int lo;
		int hi;
		int r;
		lo = int'(cfg_min) + 1;
		hi = int'(cfg_near) - 1;
		r = $urandom_range(9, 0);
		if (hi < lo)
			return $urandom;
		if (r == 0)
			return lo[RANGE_W-1:0];
		if (r == 1)
			return hi[RANGE_W-1:0];
		return $urandom_range(hi, lo);
	endfunction

	function automatic logic [RANGE_W-1:0] far_value();
		int r;
		r = $urandom_range(9, 0);
		if (r == 0)
			return cfg_min;
		if (r < 3)
			return $urandom_range(int'(cfg_min), 0);
		if (r == 3)
			return cfg_near;
		return $urandom_range(65535, int'(cfg_near));
	endfunction

	// near and far runs of random length; noisy scans use raw ranges instead
	task automatic run_scan(input int len, input bit noisy);
		int                 run_left;
		bit                 in_near;
		logic [RANGE_W-1:0] rng;
		in_near = $urandom_range(1, 0);
		run_left = $urandom_range(6, 1);
		for (int b = 0; b < len; b++) begin
			if (noisy) begin
				rng = $urandom;
			end else begin
				if (run_left == 0) begin
					in_near = !in_near;
					run_left = in_near ? $urandom_range(6, 1) : $urandom_range(4, 1);
				end
				rng = in_near ? near_value() : far_value();
				run_left--;
			end
			send_beam(rng, b == len - 1);
		end
	endtask

	task automatic test_directed_scans();
		int scan_a [13] = '{0, 65535, 50, 51, 999, 1000, 700, 300, 500, 0, 999, 65535, 400};
		foreach (scan_a[i])
			send_beam(scan_a[i], i == 12);
		send_beam(16'd300, 1'b0);
		send_beam(16'd200, 1'b0);
		send_beam(16'd5000, 1'b1);
		send_beam(16'd500, 1'b1);
		send_beam(16'd0, 1'b1);
	endtask

	task automatic test_register_corners();
		wait_idle();
		for (int a = REG_SPARE_FIRST; a < (1 << CFG_IDX_W); a++)
			write_reg(a[CFG_IDX_W-1:0], $urandom);
		run_scan(20, 1'b0);
		wait_idle();
		set_config(500, 500, RST_ANGLE_START, RST_ANGLE_STEP, 64);
		run_scan(24, 1'b0);
		wait_idle();
		set_config(65535, 0, RST_ANGLE_START, RST_ANGLE_STEP, 64);
		run_scan(24, 1'b1);
		wait_idle();
		set_config(0, 65535, 3141593, 0, 64);
		run_scan(24, 1'b0);
		wait_idle();
		set_config(0, 65535, -23'sd3141593, 100000, 64);
		run_scan(24, 1'b1);
		wait_idle();
		set_config(10, 60000, 23'h3FFFFF, 131071, 127);
		run_scan(24, 1'b0);
		wait_idle();
		set_config(10, 60000, 23'h400000, 1, 0);
		run_scan(24, 1'b0);
		wait_idle();
		set_config(100, 2000, 0, 50000, 1);
		run_scan(24, 1'b0);
		wait_idle();
		set_config(100, 2000, 1570796, 1, 2);
		run_scan(24, 1'b0);
	endtask

	// far lead-in, then one-beam clusters: start beam saturates and the limit drops the tail
	task automatic test_long_scan();
		wait_idle();
		src_jitter = 1'b0;
		sink_jitter = 1'b0;
		set_config(0, 65535, -23'sd3141593, 12345, 127);
		for (int b = 0; b < 600; b++) begin
			if (b >= 300 && b % 2 == 0)
				send_beam(near_value(), b == 599);
			else
				send_beam($urandom_range(1, 0) ? 16'd0 : 16'd65535, b == 599);
		end
	endtask

	task automatic test_random_phases();
		int  phase_beams;
		int  r;
		int  len;
		logic [CFG_DATA_W-1:0] min_mm;
		logic [CFG_DATA_W-1:0] near_mm;
		logic [CFG_DATA_W-1:0] start_urad;
		logic [CFG_DATA_W-1:0] step_urad;
		logic [CFG_DATA_W-1:0] max_obst;
		for (int phase = 0; phase < 10; phase++) begin
			wait_idle();
			r = $urandom_range(3, 0);
			src_jitter = r[0];
			sink_jitter = r[1];
			min_mm = ($urandom_range(9, 0) < 2) ? 0 : $urandom_range(300, 0);
			r = $urandom_range(9, 0);
			near_mm = (r < 6) ? $urandom_range(3000, int'(min_mm) + 2) :
				(r < 8) ? 65535 : $urandom_range(65535, 0);
			start_urad = ($urandom_range(9, 0) < 7) ? $urandom_range(6283186, 0) - 3141593 :
				$urandom;
			r = $urandom_range(9, 0);
			step_urad = (r < 7) ? $urandom_range(100000, 1) : (r == 7) ? 0 :
				(r == 8) ? 131071 : $urandom;
			r = $urandom_range(9, 0);
			max_obst = (r < 6) ? 64 : (r < 8) ? $urandom_range(4, 0) : $urandom_range(127, 0);
			set_config(min_mm, near_mm, start_urad, step_urad, max_obst);
			phase_beams = 0;
			while (phase_beams < 85) begin
				r = $urandom_range(99, 0);
				len = (r < 10) ? 1 : (r < 90) ? $urandom_range(30, 2) : $urandom_range(120, 31);
				run_scan(len, $urandom_range(99, 0) < 20);
				phase_beams += len;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_scans();
		test_register_corners();
		test_long_scan();
		test_random_phases();
		wait_idle();
		$display("covered %0d beams: directed scans, register corners, a saturating long scan",
			beams_sent);
		$display("and random phases; checked %0d obstacles and %0d scan summaries",
			obstacles_seen, summaries_seen);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (sink_jitter && $urandom_range(99, 0) < 25)
					stall_left = pick_gap();
			end
		end
	end

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("result with no pending request: tdata %h tlast %b", m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("obstacle_x_mm", want.x, $signed(m_tdata[16:0]));
				check_field("obstacle_y_mm", want.y, $signed(m_tdata[33:17]));
				check_field("start_beam", want.beam, m_tdata[42:34]);
				check_field("nearest_range_mm", want.nearest, m_tdata[58:43]);
				check_field("scan_summary", want.summary, m_tlast);
				check_field("obstacle_count", want.count, m_tdata[65:59]);
				if (m_tlast)
					summaries_seen++;
				else
					obstacles_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_reports.size());
			$display("FAILURE");
			$finish;
		end
	end

endmodule

// File: filelist.f
hw/rtl/lrce_pkg.sv
hw/rtl/lrce_angle.sv
hw/rtl/lrce_cordic.sv
hw/rtl/lidar_range_cluster_extractor_core.sv
test/tb.sv
